FILE: src/jkscan_pkg.sv
`default_nettype none

package jkscan_pkg;

  localparam int MAX_KEY_BYTES     = 32;
  localparam int MAX_DEPTH_DEFAULT = 255;

  localparam int KEY_LEN_W  = 6;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_WORD_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3  = 3'd4;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef struct packed {
    logic [KEY_LEN_W-1:0]                  length;
    logic [KEY_WORDS-1:0][KEY_WORD_W-1:0]  words;
  } key_cfg_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    case (b)
      8'h6E:   unescape = 8'h0A;
      8'h74:   unescape = 8'h09;
      8'h72:   unescape = 8'h0D;
      8'h62:   unescape = 8'h08;
      8'h66:   unescape = 8'h0C;
      default: unescape = b;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: src/json_top_level_key_scanner_core.sv
// Scans a JSON message one byte per item and reports whether a configured
// key appears as a string key at the top level of its outer object.
// Input channel (s_axis): tdata carries one message byte, tlast marks the
// final byte of the message. Output channel (m_axis): one item per message,
// issued for the final byte; tdata bit 0 is the found flag.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 key length, 1 to 4 the key bytes eight at a time, byte 0 lowest).
// Registers must only change while no message is in flight.
// Throughput is one byte per clock unless a held result stalls the input.
// A byte is registered on acceptance and then processed by the parser, whose
// state is updated in a single step; the result for the final byte is then
// registered in the m_axis output register, which holds one result while
// the receiver stalls; further bytes are still taken until the next final
// byte reaches the parser, which then waits for the held result to be taken.
// Reset clears the parser state, the key registers and the valid flags of
// both pipeline registers; the block is ready in the cycle after reset.
`default_nettype none

module json_top_level_key_scanner_core #(
  parameter int MAX_DEPTH = jkscan_pkg::MAX_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // text_byte
  input  wire logic                            s_axis_tlast,  // end_of_message
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // key_found, zeros
  input  wire logic                            cfg_wr_en,
  input  wire logic [jkscan_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jkscan_pkg::KEY_WORD_W-1:0] cfg_data
);
  import jkscan_pkg::*;

  key_cfg_t   key_cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       found;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH: key_cfg.length   <= cfg_data[KEY_LEN_W-1:0];
        CFG_KEY_WORD0:  key_cfg.words[0] <= cfg_data;
        CFG_KEY_WORD1:  key_cfg.words[1] <= cfg_data;
        CFG_KEY_WORD2:  key_cfg.words[2] <= cfg_data;
        CFG_KEY_WORD3:  key_cfg.words[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  jkscan_parser #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .step_en        (advance),
    .text_byte      (in_byte),
    .end_of_message (in_last),
    .key_cfg        (key_cfg),
    .key_found      (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_axis_tdata <= {7'd0, found};
    end
  end

endmodule

`default_nettype wire

FILE: src/jkscan_parser.sv
`default_nettype none

module jkscan_parser #(
  parameter int MAX_DEPTH = jkscan_pkg::MAX_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step_en,
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_of_message,
  input  wire jkscan_pkg::key_cfg_t key_cfg,
  output logic                     key_found
);
  import jkscan_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1) + 1;
  localparam logic signed [DW-1:0] DEPTH_HI  = DW'(MAX_DEPTH);
  localparam logic signed [DW-1:0] DEPTH_LO  = -DEPTH_HI;
  localparam logic signed [DW-1:0] DEPTH_ONE = DW'(1);

  localparam logic [2:0] PH_AWAIT   = 3'd0;
  localparam logic [2:0] PH_OBJECT  = 3'd1;
  localparam logic [2:0] PH_STRING  = 3'd2;
  localparam logic [2:0] PH_ESCAPE  = 3'd3;
  localparam logic [2:0] PH_DECIDED = 3'd4;

  localparam logic [KEY_LEN_W-1:0] KEY_MAX = KEY_LEN_W'(MAX_KEY_BYTES);

  logic [2:0]           phase, phase_next;
  logic signed [DW-1:0] depth, depth_next;
  logic                 key_wanted, key_wanted_next;
  logic [KEY_LEN_W-1:0] pos, pos_next;
  logic                 match, match_next;
  logic                 found, found_next;

  logic [2:0] phase_step;
  logic       take;
  logic       do_close;
  logic [7:0] take_byte;
  logic [7:0] key_byte;
  logic       depth_zero;

  assign depth_zero = (depth == '0);
  assign key_byte   = key_cfg.words[pos[4:3]][pos[2:0]*8 +: 8];

  always_comb begin
    phase_step      = phase;
    depth_next      = depth;
    key_wanted_next = key_wanted;
    pos_next        = pos;
    match_next      = match;
    found_next      = found;
    take            = 1'b0;
    do_close        = 1'b0;
    take_byte       = text_byte;

    unique case (phase)
      PH_AWAIT: begin
        if (!is_blank(text_byte)) begin
          phase_step = (text_byte == CH_LBRACE) ? PH_OBJECT : PH_DECIDED;
        end
      end
      PH_OBJECT: begin
        if (!is_blank(text_byte)) begin
          if (text_byte == CH_RBRACE && depth_zero) begin
            phase_step = PH_DECIDED;
          end else if (text_byte == CH_COMMA && depth_zero) begin
            key_wanted_next = 1'b1;
          end else if (text_byte == CH_COLON && depth_zero) begin
            key_wanted_next = 1'b0;
          end else if (text_byte == CH_LBRACE || text_byte == CH_LBRACKET) begin
            if (depth < DEPTH_HI) depth_next = depth + DEPTH_ONE;
          end else if (text_byte == CH_RBRACE || text_byte == CH_RBRACKET) begin
            if (depth > DEPTH_LO) depth_next = depth - DEPTH_ONE;
          end else if (text_byte == CH_QUOTE) begin
            phase_step = PH_STRING;
            pos_next   = '0;
            match_next = 1'b1;
          end
        end
      end
      PH_STRING: begin
        if (text_byte == CH_QUOTE) begin
          do_close = 1'b1;
        end else if (text_byte == CH_BACKSLASH && !end_of_message) begin
          phase_step = PH_ESCAPE;
        end else begin
          take = 1'b1;
        end
      end
      PH_ESCAPE: begin
        take_byte  = unescape(text_byte);
        take       = 1'b1;
        phase_step = PH_STRING;
      end
      default: begin
      end
    endcase

    if (take && match) begin
      if (pos >= key_cfg.length || pos >= KEY_MAX) begin
        match_next = 1'b0;
      end else if (key_byte != take_byte) begin
        match_next = 1'b0;
      end else begin
        pos_next = pos + 1'b1;
      end
    end

    // A string still open on the final byte is compared as if it closed.
    if (end_of_message && (phase_step == PH_STRING || phase_step == PH_ESCAPE)) begin
      do_close = 1'b1;
    end

    phase_next = phase_step;
    if (do_close) begin
      phase_next = PH_OBJECT;
      if (depth_zero && key_wanted && match_next && key_cfg.length <= KEY_MAX &&
          pos_next == key_cfg.length) begin
        phase_next = PH_DECIDED;
        found_next = 1'b1;
      end
    end
  end

  assign key_found = found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_AWAIT;
      depth      <= '0;
      key_wanted <= 1'b1;
      pos        <= '0;
      match      <= 1'b1;
      found      <= 1'b0;
    end else if (step_en) begin
      if (end_of_message) begin
        phase      <= PH_AWAIT;
        depth      <= '0;
        key_wanted <= 1'b1;
        pos        <= '0;
        match      <= 1'b1;
        found      <= 1'b0;
      end else begin
        phase      <= phase_next;
        depth      <= depth_next;
        key_wanted <= key_wanted_next;
        pos        <= pos_next;
        match      <= match_next;
        found      <= found_next;
      end
    end
  end

endmodule

`default_nettype wire
